// ===== design/swz_pkg.sv =====
// Shared types and constants for the texture block swizzle engine.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package swz_pkg;

  localparam int BAND_ROWS   = 8;
  localparam int BLOCK_WORDS = 4;
  localparam int BLOCK_ROWS  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int LOG2_W      = 4;
  localparam int BAND_W      = 7;
  localparam int WORD_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WORDS_LOG2 = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_TOTAL     = 1'b1;

  localparam logic [LOG2_W-1:0] ROW_WORDS_LOG2_RESET = 4'd9;
  localparam logic [BAND_W-1:0] BAND_TOTAL_RESET     = 7'd64;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED       = 2'd0,
    ST_PUSH_REFUSED = 2'd1,
    ST_POPPED       = 2'd2,
    ST_POP_REFUSED  = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    last;
  } swz_tag_t;

endpackage

// ===== design/swz_front.sv =====
// Front end: accepts transactions, classifies them against the band counters,
// holds the configuration and the write and read pointers. Uses swz_pkg.
`timescale 1ns / 1ps

module swz_front #(
  parameter int MAX_ROW_WORDS = 512,
  localparam int ADDR_W = $clog2(2 * swz_pkg::BAND_ROWS * MAX_ROW_WORDS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                cmd,
  input  logic [swz_pkg::WORD_W-1:0]          pixel_word,
  input  logic                                cfg_write,
  input  logic [swz_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [swz_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                ent_write,
  output swz_pkg::swz_tag_t                   ent_tag,
  output logic [ADDR_W-1:0]                   ent_addr,
  output logic [swz_pkg::WORD_W-1:0]          ent_wdata
);

  localparam int MAX_LOG2  = $clog2(MAX_ROW_WORDS + 1) - 1;
  localparam int COL_W     = MAX_LOG2;
  localparam int POS_W     = MAX_LOG2 + 3;
  localparam int LG_W      = $clog2(MAX_LOG2 + 1);
  localparam int BANK_WORDS = swz_pkg::BAND_ROWS * MAX_ROW_WORDS;

  logic [swz_pkg::LOG2_W-1:0] row_words_log2;
  logic [swz_pkg::BAND_W-1:0] band_total;
  logic [COL_W-1:0]           write_column;
  logic [2:0]                 write_row;
  logic                       write_bank;
  logic [POS_W-1:0]           read_position;
  logic                       read_bank;
  logic [1:0]                 full_bands;
  logic [swz_pkg::BAND_W-1:0] bands_written;
  logic [swz_pkg::BAND_W-1:0] bands_read;

  logic [LG_W-1:0]            lg;
  logic [COL_W-1:0]           col_mask;
  logic                       col_last;
  logic                       row_last;
  logic                       pos_last;
  logic                       push_ok;
  logic                       pop_ok;
  logic [POS_W-1:0]           blk_shift;
  logic [COL_W-1:0]           rd_col;
  logic [2:0]                 rd_row;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [swz_pkg::BAND_W-1:0] bands_read_next;

  always_comb begin
    if (row_words_log2 > swz_pkg::LOG2_W'(MAX_LOG2)) begin
      lg = LG_W'(MAX_LOG2);
    end else if (row_words_log2 < swz_pkg::LOG2_W'(2)) begin
      lg = LG_W'(2);
    end else begin
      lg = LG_W'(row_words_log2);
    end
  end

  assign col_mask = {COL_W{1'b1}} >> (LG_W'(MAX_LOG2) - lg);
  assign col_last = &(write_column | ~col_mask);
  assign row_last = (write_row == 3'(swz_pkg::BAND_ROWS - 1));
  assign pos_last = &(read_position | ~{col_mask, 3'b111});

  assign push_ok = (bands_written < band_total) && (full_bands != 2'd2);
  assign pop_ok  = (full_bands != 2'd0);

  assign blk_shift = read_position >> 5;
  assign rd_col    = COL_W'({blk_shift, read_position[1:0]});
  assign rd_row    = read_position[4:2];

  assign wr_addr = ADDR_W'(write_bank) * ADDR_W'(BANK_WORDS)
                 + ADDR_W'(write_row) * ADDR_W'(MAX_ROW_WORDS)
                 + ADDR_W'(write_column);
  assign rd_addr = ADDR_W'(read_bank) * ADDR_W'(BANK_WORDS)
                 + ADDR_W'(rd_row) * ADDR_W'(MAX_ROW_WORDS)
                 + ADDR_W'(rd_col);

  assign bands_read_next = bands_read + swz_pkg::BAND_W'(1);

  always_comb begin
    ent_tag.last = 1'b0;
    if (cmd == swz_pkg::CMD_PUSH) begin
      ent_tag.status = push_ok ? swz_pkg::ST_PUSHED : swz_pkg::ST_PUSH_REFUSED;
      ent_addr       = wr_addr;
    end else begin
      ent_tag.status = pop_ok ? swz_pkg::ST_POPPED : swz_pkg::ST_POP_REFUSED;
      ent_addr       = rd_addr;
      ent_tag.last   = pop_ok && pos_last && (bands_read_next == band_total);
    end
  end

  assign ent_write = (cmd == swz_pkg::CMD_PUSH) && push_ok;
  assign ent_wdata = pixel_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_words_log2 <= swz_pkg::ROW_WORDS_LOG2_RESET;
      band_total     <= swz_pkg::BAND_TOTAL_RESET;
      write_column   <= '0;
      write_row      <= '0;
      write_bank     <= 1'b0;
      read_position  <= '0;
      read_bank      <= 1'b0;
      full_bands     <= '0;
      bands_written  <= '0;
      bands_read     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        swz_pkg::CFG_ROW_WORDS_LOG2: row_words_log2 <= cfg_data[swz_pkg::LOG2_W-1:0];
        default:                     band_total     <= cfg_data;
      endcase
      write_column  <= '0;
      write_row     <= '0;
      write_bank    <= 1'b0;
      read_position <= '0;
      read_bank     <= 1'b0;
      full_bands    <= '0;
      bands_written <= '0;
      bands_read    <= '0;
    end else if (accept) begin
      if (cmd == swz_pkg::CMD_PUSH) begin
        if (push_ok) begin
          if (col_last) begin
            write_column <= '0;
            if (row_last) begin
              write_row     <= '0;
              write_bank    <= ~write_bank;
              full_bands    <= full_bands + 2'd1;
              bands_written <= bands_written + swz_pkg::BAND_W'(1);
            end else begin
              write_row <= write_row + 3'd1;
            end
          end else begin
            write_column <= write_column + COL_W'(1);
          end
        end
      end else if (pop_ok) begin
        if (pos_last) begin
          read_position <= '0;
          read_bank     <= ~read_bank;
          full_bands    <= full_bands - 2'd1;
          bands_read    <= bands_read_next;
        end else begin
          read_position <= read_position + POS_W'(1);
        end
      end
    end
  end

endmodule

// ===== design/swz_queue.sv =====
// Short first-in first-out queue that decouples the front end from the back end.
// Generic payload vector; depth comes from swz_pkg.
`timescale 1ns / 1ps

module swz_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = swz_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/swz_back.sv =====
// Back end: carries out queued transactions against the two-bank band store
// and holds the result register. Uses swz_pkg.
`timescale 1ns / 1ps

module swz_back #(
  parameter int ADDR_W = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic                       q_write,
  input  swz_pkg::swz_tag_t          q_tag,
  input  logic [ADDR_W-1:0]          q_addr,
  input  logic [swz_pkg::WORD_W-1:0] q_wdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [swz_pkg::WORD_W-1:0] out_word,
  output logic                       image_last
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [swz_pkg::WORD_W-1:0] band_store [DEPTH];
  logic [swz_pkg::WORD_W-1:0] rd_word;
  swz_pkg::swz_tag_t          tag;
  logic                       advance;

  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_write) begin
        band_store[q_addr] <= q_wdata;
      end
      rd_word <= band_store[q_addr];
      tag     <= q_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid;
    end
  end

  assign status     = tag.status;
  assign out_word   = (tag.status == swz_pkg::ST_POPPED) ? rd_word : '0;
  assign image_last = tag.last;

endmodule

// ===== design/texture_block_swizzle.sv =====
// Top level of the texture block swizzle engine: front end, queue and back end.
// Depends on swz_pkg, swz_front, swz_queue and swz_back.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   cmd, pixel_word
//   out      out_valid / out_ready status, out_word, image_last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction is accepted per cycle while the queue is not full; its result passes
// through the queue entry and then the registered band store read before it appears.
// A four-entry queue lets the input run on while the output is stalled.
// Reset is synchronous and needs no clearing pass; the band store is not cleared.
// Configuration writes are always taken and rewind all pointers.
`timescale 1ns / 1ps

module texture_block_swizzle #(
  parameter int MAX_ROW_WORDS = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [31:0]                     pixel_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [31:0]                     out_word,
  output logic                            image_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swz_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swz_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W  = $clog2(2 * swz_pkg::BAND_ROWS * MAX_ROW_WORDS);
  localparam int ENTRY_W = 1 + $bits(swz_pkg::swz_tag_t) + ADDR_W + swz_pkg::WORD_W;

  logic                       accept;
  logic                       ent_write;
  swz_pkg::swz_tag_t          ent_tag;
  logic [ADDR_W-1:0]          ent_addr;
  logic [swz_pkg::WORD_W-1:0] ent_wdata;
  logic                       q_not_empty;
  logic                       q_pop;
  logic [ENTRY_W-1:0]         q_head;
  logic                       hd_write;
  swz_pkg::swz_tag_t          hd_tag;
  logic [ADDR_W-1:0]          hd_addr;
  logic [swz_pkg::WORD_W-1:0] hd_wdata;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  swz_front #(
    .MAX_ROW_WORDS(MAX_ROW_WORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .pixel_word(pixel_word),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ent_write (ent_write),
    .ent_tag   (ent_tag),
    .ent_addr  (ent_addr),
    .ent_wdata (ent_wdata)
  );

  swz_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({ent_write, ent_tag, ent_addr, ent_wdata}),
    .not_full (in_ready),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_data(q_head)
  );

  assign {hd_write, hd_tag, hd_addr, hd_wdata} = q_head;

  swz_back #(
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_write   (hd_write),
    .q_tag     (hd_tag),
    .q_addr    (hd_addr),
    .q_wdata   (hd_wdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_word  (out_word),
    .image_last(image_last)
  );

  a_last_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_last |-> status == swz_pkg::ST_POPPED)
    else $error("image_last flagged on a result that is not a popped word");

  a_full_queue_means_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("queue full while the result register is empty");

endmodule

// ===== dv/texture_block_swizzle_test.sv =====
// Self-checking testbench for texture_block_swizzle: raster pushes and swizzled pops are
// predicted in order and each result transaction is compared with the oldest expectation.
// Depends on swz_pkg and the texture_block_swizzle design; needs no other file.
`timescale 1ns / 1ps

module texture_block_swizzle_test;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_WORDS     = 512;
  localparam int MAX_LOG2      = $clog2(MAX_WORDS);
  localparam int STORE_WORDS   = 2 * swz_pkg::BAND_ROWS * MAX_WORDS;
  localparam int RANDOM_ITEMS  = 870;
  localparam int FINAL_ITEMS   = 64;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    swz_pkg::status_t status;
    logic [31:0]      word;
    logic             last;
  } swizzle_result_t;

  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_PUSH,
    ROW_POP
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t                      kind;
    logic [swz_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [15:0]                     count;
    logic [31:0]                     value;
    logic                            typed;
    swz_pkg::status_t                status;
  } plan_row_t;

  localparam int PLAN_ROWS = 21;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_POP, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0000_0000, 1'b1,
      swz_pkg::ST_POP_REFUSED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'hFFFF_FFFF, 1'b1,
      swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0000_0000, 1'b1,
      swz_pkg::ST_PUSHED},
    '{ROW_CONFIG, swz_pkg::CFG_BAND_TOTAL, 16'd0, 32'd0, 1'b0, swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h5A5A_A5A5, 1'b1,
      swz_pkg::ST_PUSH_REFUSED},
    '{ROW_POP, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0000_0000, 1'b1,
      swz_pkg::ST_POP_REFUSED},
    '{ROW_CONFIG, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd0, 32'd0, 1'b0, swz_pkg::ST_PUSHED},
    '{ROW_CONFIG, swz_pkg::CFG_BAND_TOTAL, 16'd0, 32'd2, 1'b0, swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'hFFFF_FFFF, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0000_0000, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd62, 32'h1234_0000, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'hDEAD_BEEF, 1'b1,
      swz_pkg::ST_PUSH_REFUSED},
    '{ROW_POP, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd64, 32'h0000_0000, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_POP, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0000_0000, 1'b1,
      swz_pkg::ST_POP_REFUSED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd1, 32'h0F0F_0F0F, 1'b1,
      swz_pkg::ST_PUSH_REFUSED},
    '{ROW_CONFIG, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd0, 32'd1, 1'b0, swz_pkg::ST_PUSHED},
    '{ROW_CONFIG, swz_pkg::CFG_BAND_TOTAL, 16'd0, 32'd1, 1'b0, swz_pkg::ST_PUSHED},
    '{ROW_PUSH, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd40, 32'h8000_0000, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_POP, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd33, 32'h0000_0000, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_CONFIG, swz_pkg::CFG_ROW_WORDS_LOG2, 16'd0, 32'h0000_0073, 1'b0,
      swz_pkg::ST_PUSHED},
    '{ROW_CONFIG, swz_pkg::CFG_BAND_TOTAL, 16'd0, 32'd127, 1'b0, swz_pkg::ST_PUSHED}
  };

  logic                            clk        = 1'b0;
  logic                            rst        = 1'b1;
  logic                            in_valid   = 1'b0;
  logic                            cmd        = swz_pkg::CMD_PUSH;
  logic [31:0]                     pixel_word = '0;
  logic                            out_ready  = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic [swz_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [swz_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                            in_ready;
  logic                            out_valid;
  logic [1:0]                      status;
  logic [31:0]                     out_word;
  logic                            image_last;
  logic                            cfg_ready;

  swizzle_result_t expected_results [$];
  swizzle_result_t head_result;
  int              error_count   = 0;
  int unsigned     sent_items    = 0;
  int unsigned     cycle_count   = 0;
  int unsigned     tx_idle_pct   = 28;
  int unsigned     rx_idle_pct   = 63;
  int unsigned     hold_requests = 0;
  int unsigned     hold_taken    = 0;
  int unsigned     hold_left     = 0;

  logic [31:0] mirror_store [STORE_WORDS];
  logic [3:0]  row_log2_q;
  logic [6:0]  band_total_q;
  logic [6:0]  bands_wr_q;
  logic [6:0]  bands_rd_q;
  int unsigned wr_col_q;
  int unsigned wr_row_q;
  int unsigned wr_bank_q;
  int unsigned rd_pos_q;
  int unsigned rd_bank_q;
  int unsigned full_bands_q;

  texture_block_swizzle #(
    .MAX_ROW_WORDS(MAX_WORDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .pixel_word(pixel_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_word(out_word),
    .image_last(image_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic void rewind_pointers();
    wr_col_q     = 0;
    wr_row_q     = 0;
    wr_bank_q    = 0;
    rd_pos_q     = 0;
    rd_bank_q    = 0;
    full_bands_q = 0;
    bands_wr_q   = '0;
    bands_rd_q   = '0;
  endfunction

  function automatic int unsigned row_word_count();
    int unsigned lg;
    lg = row_log2_q;
    if (lg > MAX_LOG2) lg = MAX_LOG2;
    if (lg < 2) lg = 2;
    return 1 << lg;
  endfunction

  function automatic int unsigned store_addr(input int unsigned bank, input int unsigned row,
                                             input int unsigned col);
    return ((bank & 1) * swz_pkg::BAND_ROWS * MAX_WORDS + row * MAX_WORDS + col)
           % STORE_WORDS;
  endfunction

  function automatic swizzle_result_t predict_swizzle(input logic c, input logic [31:0] p);
    swizzle_result_t r;
    int unsigned     words;
    int unsigned     in_block;
    int unsigned     col;
    r.status = swz_pkg::ST_PUSHED;
    r.word   = '0;
    r.last   = 1'b0;
    words    = row_word_count();
    if (c == swz_pkg::CMD_PUSH) begin
      if (bands_wr_q >= band_total_q || full_bands_q >= 2) begin
        r.status = swz_pkg::ST_PUSH_REFUSED;
      end else begin
        mirror_store[store_addr(wr_bank_q, wr_row_q, wr_col_q)] = p;
        wr_col_q++;
        if (wr_col_q >= words) begin
          wr_col_q = 0;
          wr_row_q++;
          if (wr_row_q >= swz_pkg::BAND_ROWS) begin
            wr_row_q  = 0;
            wr_bank_q = wr_bank_q ^ 1;
            full_bands_q++;
            bands_wr_q = bands_wr_q + 7'd1;
          end
        end
      end
    end else if (full_bands_q == 0) begin
      r.status = swz_pkg::ST_POP_REFUSED;
    end else begin
      in_block = rd_pos_q % (swz_pkg::BLOCK_WORDS * swz_pkg::BLOCK_ROWS);
      col      = (rd_pos_q / (swz_pkg::BLOCK_WORDS * swz_pkg::BLOCK_ROWS))
                 * swz_pkg::BLOCK_WORDS + in_block % swz_pkg::BLOCK_WORDS;
      r.status = swz_pkg::ST_POPPED;
      r.word   = mirror_store[store_addr(rd_bank_q, in_block / swz_pkg::BLOCK_WORDS, col)];
      rd_pos_q++;
      if (rd_pos_q >= words * swz_pkg::BAND_ROWS) begin
        rd_pos_q  = 0;
        rd_bank_q = rd_bank_q ^ 1;
        full_bands_q--;
        bands_rd_q = bands_rd_q + 7'd1;
        r.last     = (bands_rd_q == band_total_q);
      end
    end
    return r;
  endfunction

  // Called at a falling edge; leaves in_valid high so the next transaction can follow at once.
  task automatic drive_item(input logic c, input logic [31:0] p, input logic typed,
                            input swz_pkg::status_t typed_status);
    swizzle_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    pixel_word <= p;
    do @(posedge clk); while (!in_ready);
    r = predict_swizzle(c, p);
    if (typed) begin
      r.status = typed_status;
      r.word   = '0;
      r.last   = 1'b0;
    end
    expected_results.push_back(r);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [swz_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [swz_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == swz_pkg::CFG_ROW_WORDS_LOG2) row_log2_q = data[3:0];
    else band_total_q = data[6:0];
    rewind_pointers();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic that fills and drains bands, with some blind commands mixed in.
  task automatic run_phase(input logic [6:0] log2_data, input logic [6:0] bands,
                           input logic pressure, input int unsigned max_items);
    int unsigned budget;
    int unsigned n;
    logic        c;
    logic        can_push;
    logic        can_pop;
    write_config(swz_pkg::CFG_ROW_WORDS_LOG2, log2_data);
    write_config(swz_pkg::CFG_BAND_TOTAL, bands);
    budget = 2 * swz_pkg::BAND_ROWS * row_word_count()
             * ((int'(bands) > 3) ? 3 : int'(bands)) + 16;
    if (budget > max_items) budget = max_items;
    if (pressure) hold_requests++;
    for (n = 0; n < budget; n++) begin
      if ((pressure && n == 40) || $urandom_range(299) == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 12) begin
        c = 1'($urandom_range(1));
      end else begin
        can_push = (bands_wr_q < band_total_q) && (full_bands_q < 2);
        can_pop  = (full_bands_q != 0);
        if (can_push && can_pop) c = 1'($urandom_range(1));
        else if (can_pop) c = swz_pkg::CMD_POP;
        else c = swz_pkg::CMD_PUSH;
      end
      drive_item(c, $urandom(), 1'b0, swz_pkg::ST_PUSHED);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation: status %0d word %08h", status,
               out_word);
        error_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, status);
          error_count++;
        end
        if (out_word !== head_result.word) begin
          $error("out_word: expected %08h, actual %08h", head_result.word, out_word);
          error_count++;
        end
        if (image_last !== head_result.last) begin
          $error("image_last: expected %0b, actual %0b", head_result.last, image_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("texture_block_swizzle_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned i;
    int unsigned stage;
    int unsigned stage_goal;
    int unsigned pick;
    logic        first;
    logic [6:0]  log2_data;
    logic [6:0]  bands;
    row_log2_q   = swz_pkg::ROW_WORDS_LOG2_RESET;
    band_total_q = swz_pkg::BAND_TOTAL_RESET;
    rewind_pointers();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (DIRECTED_PLAN[row].kind == ROW_CONFIG) begin
        write_config(DIRECTED_PLAN[row].reg_index,
                     DIRECTED_PLAN[row].value[swz_pkg::CFG_DATA_W-1:0]);
      end else begin
        for (i = 0; i < DIRECTED_PLAN[row].count; i++) begin
          drive_item((DIRECTED_PLAN[row].kind == ROW_POP) ? swz_pkg::CMD_POP
                                                           : swz_pkg::CMD_PUSH,
                     DIRECTED_PLAN[row].value + i, DIRECTED_PLAN[row].typed,
                     DIRECTED_PLAN[row].status);
        end
      end
    end

    for (stage = 0; stage < 3; stage++) begin
      tx_idle_pct = (stage == 0) ? 28 : (stage == 1) ? 63 : 0;
      rx_idle_pct = (stage == 0) ? 63 : (stage == 1) ? 28 : 0;
      stage_goal  = sent_items + RANDOM_ITEMS / 3;
      first       = 1'b1;
      while (sent_items < stage_goal) begin
        pick      = $urandom_range(99);
        log2_data = {3'($urandom_range(7)),
                     4'((pick < 70) ? $urandom_range(3) : $urandom_range(6, 4))};
        pick      = $urandom_range(99);
        if (first || pick < 80) bands = 7'($urandom_range(3, 1));
        else if (pick < 90) bands = '0;
        else bands = 7'($urandom_range(127, 4));
        run_phase(log2_data, bands, first, stage_goal - sent_items);
        first = 1'b0;
      end
    end

    // The start of a full-width band, with the row-width register above its usable range.
    run_phase(7'h7F, 7'd1, 1'b0, FINAL_ITEMS);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("texture_block_swizzle_test passed");
    end else begin
      $display("texture_block_swizzle_test failed");
    end
    $finish;
  end

endmodule
